### rtl/disl_pkg.sv
// Shared types and constants for the display init list sequencer.
// Used by disl_decode, disl_out_fifo, the top level and its checker.
package disl_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned VALUE_W      = 16;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned ARGS_W       = 7;

    localparam logic [VALUE_W-1:0] LONG_DELAY_RESET = 16'd500;
    localparam logic [BYTE_W-1:0]  LONG_DELAY_CODE  = 8'd255;

    localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELAY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_CMD   = 3'd1,
        PH_ARGC  = 3'd2,
        PH_ARG   = 3'd3,
        PH_DELAY = 3'd4
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } result_t;

    // Results produced by one accepted list byte (count is 0, 1 or 2).
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

### rtl/disl_decode.sv
// List parser: holds the parse state and turns each accepted byte into up to two results.
// Depends on disl_pkg.
module disl_decode (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [disl_pkg::BYTE_W-1:0]    list_byte,
    input  logic [disl_pkg::VALUE_W-1:0]   long_delay_ms,
    output disl_pkg::push_t                push
);
    import disl_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  commands_left_reg, commands_left_next;
    logic [ARGS_W-1:0]  args_left_reg, args_left_next;
    logic               delay_pending_reg, delay_pending_next;

    logic [BYTE_W-1:0]  cmd_dec;
    logic [ARGS_W-1:0]  arg_dec;
    logic               list_done;
    logic               args_done;
    logic [VALUE_W-1:0] delay_value;

    assign cmd_dec     = commands_left_reg - BYTE_W'(1);
    assign arg_dec     = args_left_reg - ARGS_W'(1);
    assign list_done   = (cmd_dec == '0);
    assign args_done   = (arg_dec == '0);
    assign delay_value = (list_byte == LONG_DELAY_CODE) ? long_delay_ms
                                                        : VALUE_W'(list_byte);

    // Next state
    always_comb
    begin
        phase_next         = phase_reg;
        commands_left_next = commands_left_reg;
        args_left_next     = args_left_reg;
        delay_pending_next = delay_pending_reg;
        case (phase_reg)
            PH_CMD:
            begin
                phase_next = PH_ARGC;
            end
            PH_ARGC:
            begin
                args_left_next     = list_byte[ARGS_W-1:0];
                delay_pending_next = list_byte[BYTE_W-1];
                if (list_byte[ARGS_W-1:0] != '0)
                    phase_next = PH_ARG;
                else if (list_byte[BYTE_W-1])
                    phase_next = PH_DELAY;
                else
                begin
                    commands_left_next = cmd_dec;
                    phase_next         = list_done ? PH_COUNT : PH_CMD;
                end
            end
            PH_ARG:
            begin
                args_left_next = arg_dec;
                if (args_done)
                begin
                    if (delay_pending_reg)
                        phase_next = PH_DELAY;
                    else
                    begin
                        commands_left_next = cmd_dec;
                        phase_next         = list_done ? PH_COUNT : PH_CMD;
                    end
                end
            end
            PH_DELAY:
            begin
                delay_pending_next = 1'b0;
                commands_left_next = cmd_dec;
                phase_next         = list_done ? PH_COUNT : PH_CMD;
            end
            default:
            begin
                commands_left_next = list_byte;
                phase_next         = (list_byte == '0) ? PH_COUNT : PH_CMD;
            end
        endcase
    end

    // Results for the current byte
    always_comb
    begin
        push       = '0;
        push.res1  = '{kind: KIND_END, value: '0, last: 1'b1};
        case (phase_reg)
            PH_CMD:
            begin
                push.count = 2'd1;
                push.res0  = '{kind: KIND_CMD, value: VALUE_W'(list_byte), last: 1'b1};
            end
            PH_ARGC:
            begin
                // no args and no delay: the command ends here; a list end result only if it was the last command
                if (list_byte == '0 && list_done)
                begin
                    push.count = 2'd1;
                    push.res0  = '{kind: KIND_END, value: '0, last: 1'b1};
                end
            end
            PH_ARG:
            begin
                push.res0 = '{kind: KIND_DATA, value: VALUE_W'(list_byte), last: 1'b1};
                if (args_done && !delay_pending_reg && list_done)
                begin
                    push.count     = 2'd2;
                    push.res0.last = 1'b0;
                end
                else
                    push.count = 2'd1;
            end
            PH_DELAY:
            begin
                push.res0 = '{kind: KIND_DELAY, value: delay_value, last: 1'b1};
                if (list_done)
                begin
                    push.count     = 2'd2;
                    push.res0.last = 1'b0;
                end
                else
                    push.count = 2'd1;
            end
            default:
            begin
                push.count = 2'd0;
            end
        endcase
        if (!accept)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_COUNT;
            commands_left_reg <= '0;
            args_left_reg     <= '0;
            delay_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            commands_left_reg <= commands_left_next;
            args_left_reg     <= args_left_next;
            delay_pending_reg <= delay_pending_next;
        end
    end

endmodule

### rtl/disl_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per request.
// Depends on disl_pkg.
module disl_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  disl_pkg::push_t            push,
    input  logic                       pop,
    output logic                       room,
    output logic                       not_empty,
    output disl_pkg::result_t          head
);
    import disl_pkg::*;

    result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + FIFO_AW'(1);
    assign not_empty     = (count_reg != '0);
    // two free slots, so any byte fits regardless of its result count
    assign room          = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign head          = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_second] <= push.res1;
    end

endmodule

### rtl/display_init_list_sequencer.sv
// Display init list sequencer: parses a packed panel init list byte by byte.
// Each list byte is accepted in the cycle it is offered while the 4-entry
// result queue has two free slots. A byte yields zero, one or two results
// (command, data, delay in ms, list end); the queue drains one result per
// cycle while out_ready is high, so a data or delay byte that also closes the
// list queues two results. A delay byte of 255 reads back as long_delay_ms.
// Depends on disl_pkg, disl_decode and disl_out_fifo.
module display_init_list_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [disl_pkg::VALUE_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [disl_pkg::BYTE_W-1:0]    list_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [disl_pkg::KIND_W-1:0]    kind,
    output logic [disl_pkg::VALUE_W-1:0]   value,
    output logic                           last_of_run
);
    import disl_pkg::*;

    logic [VALUE_W-1:0] long_delay_reg;
    logic               accept;
    logic               pop;
    push_t              push;
    result_t            head;

    assign accept = in_valid && in_ready;
    assign pop    = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            long_delay_reg <= LONG_DELAY_RESET;
        else if (cfg_wr_en)
            long_delay_reg <= cfg_wr_data;
    end

    disl_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .list_byte     (list_byte),
        .long_delay_ms (long_delay_reg),
        .push          (push)
    );

    disl_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .room      (in_ready),
        .not_empty (out_valid),
        .head      (head)
    );

    assign kind        = head.kind;
    assign value       = head.value;
    assign last_of_run = head.last;

endmodule

### rtl/disl_checker.sv
// Port-level checks for display_init_list_sequencer, bound to the top level.
// Depends on disl_pkg.
module disl_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [disl_pkg::KIND_W-1:0]    kind,
    input  logic [disl_pkg::VALUE_W-1:0]   value,
    input  logic                           last_of_run
);
    import disl_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value)
            && $stable(last_of_run))
        else $error("stalled result changed");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_END |-> last_of_run && value == '0)
        else $error("list end not last or nonzero");

    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CMD || kind == KIND_DATA) |-> value[15:8] == '0)
        else $error("command or data value exceeds a byte");

    // a command byte never causes a second result
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CMD |-> last_of_run)
        else $error("command result not last");

endmodule

bind display_init_list_sequencer disl_checker u_disl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .value       (value),
    .last_of_run (last_of_run)
);
